// ----- rtl/apq_pkg.sv -----
// Shared types and constants for the array priority queue.
// No dependencies; apq_ram aside, every other file in rtl/ refers to it by scoped names.
package apq_pkg;

    localparam int CMD_W  = 2;
    localparam int VAL_W  = 32;
    localparam int PRIO_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 8;
    localparam int ENTRY_W = VAL_W + PRIO_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic ready;        // input channel may accept a word
        logic take;         // input word accepted this cycle
        logic scan;         // one step of the maximum search
        logic shift_start;  // search finished on a dequeue, set up the gap close
        logic shift;        // one step of the gap close
        logic load;         // move the result into the output register
    } ctl_t;

    // Datapath to controller.
    typedef struct packed {
        logic in_valid;
        logic need_scan;
        logic scan_last;
        logic is_deq;
        logic shift_done;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/apq_in_if.sv -----
// Input channel of the array priority queue: valid/ready plus one command word.
// Depends on apq_pkg for field widths.
interface apq_in_if;
    logic                            valid;
    logic                            ready;
    logic [apq_pkg::CMD_W-1:0]       cmd;
    logic signed [apq_pkg::VAL_W-1:0]  value_in;
    logic signed [apq_pkg::PRIO_W-1:0] prio_in;

    modport source (output valid, output cmd, output value_in, output prio_in, input ready);
    modport sink   (input valid, input cmd, input value_in, input prio_in, output ready);
endinterface

// ----- rtl/apq_out_if.sv -----
// Output channel of the array priority queue: valid/ready plus one result word.
// Depends on apq_pkg for field widths.
interface apq_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [apq_pkg::VAL_W-1:0] value_out;
    logic [apq_pkg::STAT_W-1:0]       status;
    logic [apq_pkg::OCC_W-1:0]        occupancy;

    modport source (output valid, output value_out, output status, output occupancy, input ready);
    modport sink   (input valid, input value_out, input status, input occupancy, output ready);
endinterface

// ----- rtl/apq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module apq_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/apq_ctrl.sv -----
// Controller state machine of the array priority queue.
// Depends on apq_pkg for the state, command and status types.
module apq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  apq_pkg::stat_t stat,
    output apq_pkg::ctl_t  ctl
);

    apq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl             = '0;
        state_next      = state_reg;
        unique case (state_reg)
            apq_pkg::S_IDLE:
            begin
                ctl.ready = 1'b1;
                ctl.take  = stat.in_valid;
                if (stat.in_valid)
                begin
                    state_next = stat.need_scan ? apq_pkg::S_SCAN : apq_pkg::S_DONE;
                end
            end
            apq_pkg::S_SCAN:
            begin
                ctl.scan        = 1'b1;
                ctl.shift_start = stat.scan_last && stat.is_deq;
                if (stat.scan_last)
                begin
                    state_next = stat.is_deq ? apq_pkg::S_SHIFT : apq_pkg::S_DONE;
                end
            end
            apq_pkg::S_SHIFT:
            begin
                ctl.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = apq_pkg::S_DONE;
                end
            end
            apq_pkg::S_DONE:
            begin
                ctl.load = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = apq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = apq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/apq_dp.sv -----
// Datapath of the array priority queue: entry count, search and shift pointers,
// entry RAM and output register. Depends on apq_pkg and apq_ram.
module apq_dp #(
    parameter int DEPTH = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  apq_pkg::ctl_t                     ctl,
    output apq_pkg::stat_t                    stat,
    input  logic                              in_valid,
    input  logic [apq_pkg::CMD_W-1:0]         cmd,
    input  logic signed [apq_pkg::VAL_W-1:0]  value_in,
    input  logic signed [apq_pkg::PRIO_W-1:0] prio_in,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [apq_pkg::VAL_W-1:0]  value_out,
    output logic [apq_pkg::STAT_W-1:0]        status,
    output logic [apq_pkg::OCC_W-1:0]         occupancy
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rptr_reg, rd_idx_reg, best_idx_reg, wptr_reg;
    logic             pend_reg;
    logic signed [apq_pkg::PRIO_W-1:0] best_prio_reg;
    logic signed [apq_pkg::VAL_W-1:0]  res_value_reg;
    apq_pkg::status_t                  res_status_reg;
    apq_pkg::cmd_t                     cmd_reg;

    logic                              out_valid_reg;
    logic signed [apq_pkg::VAL_W-1:0]  out_value_reg;
    logic [apq_pkg::STAT_W-1:0]        out_status_reg;
    logic [apq_pkg::OCC_W-1:0]         out_occ_reg;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr, ram_raddr;
    logic [apq_pkg::ENTRY_W-1:0]       ram_wdata, ram_rdata;
    logic signed [apq_pkg::PRIO_W-1:0] rd_prio;
    logic signed [apq_pkg::VAL_W-1:0]  rd_value;

    logic                              is_search, full, enq_ok, take_new, rd_more;
    logic [CNT_W-1:0]                  best_idx_next;
    logic signed [apq_pkg::PRIO_W-1:0] best_prio_next;
    logic signed [apq_pkg::VAL_W-1:0]  best_value_next;

    assign is_search = (apq_pkg::cmd_t'(cmd) == apq_pkg::CMD_DEQ) ||
                       (apq_pkg::cmd_t'(cmd) == apq_pkg::CMD_PEEK);
    assign full      = (count_reg == CNT_FULL);
    assign enq_ok    = ctl.take && (apq_pkg::cmd_t'(cmd) == apq_pkg::CMD_ENQ) && !full;

    assign rd_value = ram_rdata[apq_pkg::ENTRY_W-1:apq_pkg::PRIO_W];
    assign rd_prio  = ram_rdata[apq_pkg::PRIO_W-1:0];

    // First entry always wins; later ones only on a strictly greater priority,
    // so ties go to the earliest arrival.
    assign take_new        = (rd_idx_reg == '0) || (rd_prio > best_prio_reg);
    assign best_idx_next   = take_new ? rd_idx_reg : best_idx_reg;
    assign best_prio_next  = take_new ? rd_prio : best_prio_reg;
    assign best_value_next = take_new ? rd_value : res_value_reg;

    assign rd_more = (rptr_reg < count_reg);

    assign ram_raddr = ctl.take ? '0 : rptr_reg[AW-1:0];
    assign ram_we    = enq_ok || (ctl.shift && pend_reg);
    assign ram_waddr = ctl.take ? count_reg[AW-1:0] : wptr_reg[AW-1:0];
    assign ram_wdata = ctl.take ? {value_in, prio_in} : ram_rdata;

    apq_ram #(
        .WIDTH (apq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control state: count, pointers, pending read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rptr_reg   <= '0;
            rd_idx_reg <= '0;
            wptr_reg   <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.take)
            begin
                rptr_reg   <= CNT_ONE;
                rd_idx_reg <= '0;
                if (enq_ok)
                begin
                    count_reg <= count_reg + CNT_ONE;
                end
            end
            if (ctl.shift_start)
            begin
                wptr_reg <= best_idx_next;
                rptr_reg <= best_idx_next + CNT_ONE;
                pend_reg <= 1'b0;
            end
            else if (ctl.scan)
            begin
                rd_idx_reg <= rptr_reg;
                rptr_reg   <= rptr_reg + CNT_ONE;
            end
            if (ctl.shift)
            begin
                pend_reg <= rd_more;
                if (rd_more)
                begin
                    rptr_reg <= rptr_reg + CNT_ONE;
                end
                if (pend_reg)
                begin
                    wptr_reg <= wptr_reg + CNT_ONE;
                end
                if (stat.shift_done)
                begin
                    count_reg <= count_reg - CNT_ONE;
                end
            end
        end
    end

    // Result staging; no reset needed.
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            cmd_reg       <= apq_pkg::cmd_t'(cmd);
            res_value_reg <= '0;
            unique case (apq_pkg::cmd_t'(cmd)) inside
                apq_pkg::CMD_ENQ:
                begin
                    res_status_reg <= full ? apq_pkg::ST_OVER : apq_pkg::ST_OK;
                end
                apq_pkg::CMD_DEQ, apq_pkg::CMD_PEEK:
                begin
                    res_status_reg <= (count_reg == '0) ? apq_pkg::ST_UNDER : apq_pkg::ST_OK;
                end
                default:
                begin
                    res_status_reg <= apq_pkg::ST_OK;
                end
            endcase
        end
        if (ctl.scan)
        begin
            best_idx_reg  <= best_idx_next;
            best_prio_reg <= best_prio_next;
            res_value_reg <= best_value_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
            out_occ_reg    <= apq_pkg::OCC_W'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = out_value_reg;
    assign status    = out_status_reg;
    assign occupancy = out_occ_reg;

    always_comb
    begin
        stat            = '0;
        stat.in_valid   = in_valid;
        stat.need_scan  = is_search && (count_reg != '0);
        stat.scan_last  = (rd_idx_reg == (count_reg - CNT_ONE));
        stat.is_deq     = (cmd_reg == apq_pkg::CMD_DEQ);
        stat.shift_done = !pend_reg && !rd_more;
        stat.out_free   = !out_valid_reg || out_ready;
    end

endmodule

// ----- rtl/array_priority_queue.sv -----
// Top level of the array priority queue: controller plus datapath.
// Depends on apq_pkg, apq_in_if, apq_out_if, apq_ram, apq_ctrl and apq_dp.
//
//   Channel  Dir  Handshake     Word
//   req      in   valid/ready   cmd, value_in, prio_in
//   rsp      out  valid/ready   value_out, status, occupancy
//
// One word is handled at a time; a single RAM with one registered read port sets the pace.
// Enqueue, no-op and empty dequeue/peek need no scan; peek reads each held entry once.
// Dequeue reads each held entry too, and when the served entry is not the last one held,
// the later entries are then shifted down one place, one per cycle.
// Reset clears the count and control state only.
// A stalled rsp holds its word in the output register; req is taken again once it is loaded.
module array_priority_queue #(
    parameter int DEPTH = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    apq_in_if.sink           req,
    apq_out_if.source        rsp
);

    apq_pkg::ctl_t  ctl;
    apq_pkg::stat_t stat;

    apq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    apq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .in_valid  (req.valid),
        .cmd       (req.cmd),
        .value_in  (req.value_in),
        .prio_in   (req.prio_in),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .value_out (rsp.value_out),
        .status    (rsp.status),
        .occupancy (rsp.occupancy)
    );

    // The input side is ready only while the controller is waiting for work.
    assign req.ready = ctl.ready;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the array priority queue (array_priority_queue).
// Depends on apq_pkg, apq_in_if, apq_out_if and the RTL top level; it holds its own
// queue predictor in a small scoreboard class and drives the command channel from plain tasks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import apq_pkg::*;

    localparam int DEPTH       = 128;
    localparam int ITEMS       = 1050;
    // Items at the tail of the run that go through with no idling on either side.
    localparam int CALM_ITEMS  = 150;
    // Cycles the result side holds off while the command side keeps offering words.
    localparam int HOLD_CYCLES = 400;
    // Slowest single command is a dequeue at full occupancy.
    localparam int DRAIN_CYCLES = 2 * DEPTH + 20;

    // Predictor of the queue plus the store of results still to come back.
    // Every accepted command word is noted here in acceptance order; every accepted
    // result word is compared against the oldest prediction.
    class prio_queue_model;
        typedef struct {
            logic signed [VAL_W-1:0]  value;
            logic signed [PRIO_W-1:0] prio;
        } entry_t;

        typedef struct {
            logic signed [VAL_W-1:0] value;
            status_t                 status;
            logic [OCC_W-1:0]        occupancy;
        } result_t;

        int unsigned depth;
        entry_t      held[$];
        result_t     awaited[$];
        int          failures;

        function new(int unsigned depth_cfg);
            depth    = depth_cfg;
            failures = 0;
        endfunction

        function int unsigned held_count();
            return held.size();
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function void note_command(cmd_t cmd, logic signed [VAL_W-1:0] value,
                                   logic signed [PRIO_W-1:0] prio);
            result_t r;
            entry_t  e;
            int      best;
            r.value  = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_ENQ:
                begin
                    if (held.size() >= depth)
                        r.status = ST_OVER;
                    else
                    begin
                        e.value = value;
                        e.prio  = prio;
                        held.push_back(e);
                    end
                end
                CMD_DEQ, CMD_PEEK:
                begin
                    if (held.size() == 0)
                        r.status = ST_UNDER;
                    else
                    begin
                        // Strictly greater wins, so the earliest arrival keeps a tie.
                        best = 0;
                        for (int i = 1; i < held.size(); i++)
                            if (held[i].prio > held[best].prio)
                                best = i;
                        r.value = held[best].value;
                        if (cmd == CMD_DEQ)
                            held.delete(best);
                    end
                end
                default:
                    ;
            endcase
            r.occupancy = OCC_W'(held.size());
            awaited.push_back(r);
        endfunction

        function void report(string what, longint unsigned exp_v, longint unsigned act_v);
            failures++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, what, exp_v, act_v);
        endfunction

        function void check_response(logic signed [VAL_W-1:0] value, logic [STAT_W-1:0] status,
                                     logic [OCC_W-1:0] occupancy);
            result_t r;
            if (awaited.size() == 0)
            begin
                failures++;
                $display("%0t ns: unexpected result word, expected none, actual %h/%0d/%0d",
                         $time, value, status, occupancy);
                return;
            end
            r = awaited.pop_front();
            if (value !== r.value)
                report("value_out", r.value, value);
            if (status !== r.status)
                report("status", r.status, status);
            if (occupancy !== r.occupancy)
                report("occupancy", r.occupancy, occupancy);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    apq_in_if  req_if ();
    apq_out_if rsp_if ();

    array_priority_queue #(
        .DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    prio_queue_model queue_model = new(DEPTH);

    // Shared pacing controls. The command process sets them; the result pacing process
    // reads calm and hold_req and clears the hold request once it has started counting.
    bit calm     = 1'b0;
    bit gaps_on  = 1'b1;
    bit hold_req = 1'b0;
    int sent     = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Drive one command word and wait until the queue accepts it. Called at a falling
    // edge; returns at the falling edge after acceptance with valid still high, so a
    // back-to-back word needs no second assignment to valid in the same step.
    task automatic send_word(cmd_t cmd, logic signed [VAL_W-1:0] value,
                             logic signed [PRIO_W-1:0] prio);
        req_if.valid    <= 1'b1;
        req_if.cmd      <= cmd;
        req_if.value_in <= value;
        req_if.prio_in  <= prio;
        do
            @(posedge clk);
        while (!req_if.ready);
        queue_model.note_command(cmd, value, prio);
        sent++;
        @(negedge clk);
    endtask

    // Random idle burst between command words, skipped in calm stretches.
    task automatic maybe_pause();
        if (!calm && gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // Priorities lean toward a narrow band so that ties are frequent, with the
    // extremes and fully random words mixed in so every bit is exercised.
    function automatic logic signed [PRIO_W-1:0] rand_prio();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3, 4, 5:
                     return $signed($urandom_range(0, 7)) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 15);
        case (pick)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(cmd_t cmd);
        send_word(cmd, rand_value(), rand_prio());
        maybe_pause();
    endtask

    // Result side: sample accepted words at the rising edge and hand them to the
    // scoreboard. The ready line only changes at falling edges, so it is stable here.
    initial
    begin : result_monitor
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
                queue_model.check_response(rsp_if.value_out, rsp_if.status, rsp_if.occupancy);
        end
    end

    // Result side pacing: random stall bursts within windows that either allow them or
    // not, plus a long hold-off on request that lets the command side back up.
    initial
    begin : result_pacing
        int  hold_left;
        int  stall_left;
        int  window_left;
        bit  stalls_on;
        bit  rdy;
        hold_left   = 0;
        stall_left  = 0;
        window_left = 0;
        stalls_on   = 1'b1;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (window_left == 0)
            begin
                window_left = 64;
                stalls_on   = ($urandom_range(0, 2) != 0);
            end
            window_left--;
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (!calm && stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            rsp_if.ready <= rdy;
        end
    end

    // Command side: reset, a short directed pass, then random segments of
    // fill, drain and mixed traffic, then the end-of-run drain and verdict.
    initial
    begin : stimulus
        int   seg;
        int   extra;
        int   len;
        int   pick;
        int   waited;
        bit   first_fill;
        cmd_t cmd;

        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.cmd      = CMD_ENQ;
        req_if.value_in = '0;
        req_if.prio_in  = '0;
        first_fill      = 1'b1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reads on the empty queue report underflow, a no-op reports OK, and all show zero occupancy.
        send_word(CMD_PEEK, 32'sh1234_5678, 32'sh0000_0001);
        send_word(CMD_DEQ,  32'shFFFF_FFFF, 32'shFFFF_FFFF);
        send_word(CMD_NOP,  32'sh5A5A_5A5A, 32'shA5A5_A5A5);

        // Field extremes, with a tie at the top priority between two arrivals.
        send_word(CMD_ENQ, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(CMD_ENQ, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(CMD_ENQ, 32'sh0000_0000, 32'sh0000_0000);
        send_word(CMD_ENQ, 32'shFFFF_FFFF, 32'sh7FFF_FFFF);
        send_word(CMD_ENQ, 32'sh0000_0005, 32'shFFFF_FFFF);
        send_word(CMD_PEEK, '0, '0);
        send_word(CMD_NOP,  32'shFFFF_FFFF, 32'shFFFF_FFFF);
        send_word(CMD_DEQ, '0, '0);
        send_word(CMD_DEQ, '0, '0);
        send_word(CMD_DEQ, '0, '0);

        // Three equal priorities must come out in arrival order.
        send_word(CMD_ENQ, 32'sh0000_0001, 32'sh0000_0003);
        send_word(CMD_ENQ, 32'sh0000_0002, 32'sh0000_0003);
        send_word(CMD_ENQ, 32'sh0000_0003, 32'sh0000_0003);
        send_word(CMD_DEQ, '0, '0);
        send_word(CMD_PEEK, '0, '0);
        send_word(CMD_DEQ, '0, '0);
        send_word(CMD_DEQ, '0, '0);
        send_word(CMD_DEQ, '0, '0);
        send_word(CMD_DEQ, '0, '0);
        send_word(CMD_DEQ, '0, '0);
        send_word(CMD_PEEK, '0, '0);

        while (sent < ITEMS)
        begin
            calm    = (sent >= ITEMS - CALM_ITEMS);
            gaps_on = ($urandom_range(0, 2) != 0);
            seg     = first_fill ? 0 : $urandom_range(0, 11);
            if (seg == 0)
            begin
                // Fill to the top, then push a few more to see overflow. The first
                // fill starts with a long result hold-off so the queue backs up its
                // input while words keep being offered.
                if (first_fill)
                    hold_req = 1'b1;
                first_fill = 1'b0;
                while (queue_model.held_count() < DEPTH)
                    send_random(CMD_ENQ);
                extra = $urandom_range(1, 4);
                repeat (extra)
                begin
                    pick = $urandom_range(0, 3);
                    send_random(pick == 0 ? CMD_PEEK : CMD_ENQ);
                end
            end
            else if (seg <= 2)
            begin
                // Drain completely, then read the empty queue a few times.
                while (queue_model.held_count() > 0)
                    send_random(CMD_DEQ);
                extra = $urandom_range(1, 3);
                repeat (extra)
                begin
                    pick = $urandom_range(0, 1);
                    send_random(pick == 0 ? CMD_DEQ : CMD_PEEK);
                end
            end
            else
            begin
                // Mixed traffic, weighted toward enqueue so occupancy wanders.
                len = $urandom_range(20, 60);
                repeat (len)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick <= 8)
                        cmd = CMD_ENQ;
                    else if (pick <= 14)
                        cmd = CMD_DEQ;
                    else if (pick <= 17)
                        cmd = CMD_PEEK;
                    else
                        cmd = CMD_NOP;
                    send_random(cmd);
                end
            end
        end
        req_if.valid <= 1'b0;

        // Wait for every predicted result, then give the queue time to show any
        // stray word before the verdict.
        waited = 0;
        while (queue_model.outstanding() > 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (queue_model.outstanding() > 0)
            $display("%0t ns: %0d result words never arrived", $time, queue_model.outstanding());
        if (queue_model.failures == 0 && queue_model.outstanding() == 0)
            $display("PASS array_priority_queue");
        else
            $display("FAIL array_priority_queue");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin : watchdog
        #10_000_000;
        $display("%0t ns: timeout", $time);
        $display("FAIL array_priority_queue");
        $finish;
    end

endmodule
